// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted insertion priority queue.
`default_nettype none

package spq_pkg;

  // Default number of cells in the chain.
  localparam int unsigned QueueDepth = 16;

  // Command codes.
  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdRemove = 2'd1,
    CmdPeek   = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRsvd  = 2'd3
  } status_e;

  // One stored entry.
  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  tag;
    logic [15:0] duration;
  } entry_t;

  // Command word.
  typedef struct packed {
    cmd_e        command;
    logic [15:0] entry_key;
    logic [7:0]  entry_tag;
    logic [15:0] entry_duration;
  } cmd_t;

  // Result word.
  typedef struct packed {
    status_e     status;
    logic [15:0] head_key;
    logic [7:0]  head_tag;
    logic [15:0] head_duration;
    logic        now_empty;
  } res_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_insert_priority_queue_core.sv =====
// Top level of the sorted insertion priority queue built as a chain of cells.
`default_nettype none

// The result word is registered: it appears on res_o, marked by valid_o, in the cycle after start.
// Throughput: one command per cycle; every cell compares its key in parallel.
// busy stays low, so commands may be issued back to back.
// Reset clears the entry count and the result strobe; cell contents are
// left as they are and are never shown before they have been written.
module sorted_insert_priority_queue_core #(
  parameter int unsigned QueueDepth = spq_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire spq_pkg::cmd_t in_i,
  output logic               valid_o,
  output spq_pkg::res_t      res_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                valid_q;
  spq_pkg::res_t       res_q, res_d;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     cell_entry [QueueDepth];
  logic                cell_ge    [QueueDepth];
  logic                accept, is_full, is_empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count_q == CntW'(QueueDepth));
  assign is_empty = (count_q == '0);

  assign new_entry.key      = in_i.entry_key;
  assign new_entry.tag      = in_i.entry_tag;
  assign new_entry.duration = in_i.entry_duration;

  // Command decode and the next result word.
  always_comb begin
    ctrl          = '0;
    count_d       = count_q;
    res_d         = '0;
    res_d.status  = spq_pkg::StOk;
    if (accept) begin
      case (in_i.command)
        spq_pkg::CmdInsert: begin
          if (is_full) begin
            res_d.status = spq_pkg::StFull;
          end else begin
            ctrl.do_insert = 1'b1;
            count_d        = count_q + CntW'(1);
          end
        end
        spq_pkg::CmdRemove, spq_pkg::CmdPeek: begin
          if (is_empty) begin
            res_d.status = spq_pkg::StEmpty;
          end else begin
            res_d.head_key      = cell_entry[0].key;
            res_d.head_tag      = cell_entry[0].tag;
            res_d.head_duration = cell_entry[0].duration;
            if (in_i.command == spq_pkg::CmdRemove) begin
              ctrl.do_remove = 1'b1;
              count_d        = count_q - CntW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_d.now_empty = (count_d == '0);
  end

  // The chain of cells.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic            prev_ge;
    spq_pkg::entry_t left_entry, right_entry;

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_inner
      assign prev_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .occupied_i    (count_q > CntW'(i)),
      .prev_ge_i     (prev_ge),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .ge_o          (cell_ge[i]),
      .entry_o       (cell_entry[i])
    );
  end

  // Entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // The entry count never passes the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("entry count exceeds queue depth");

  // A result word is only shown for a command taken the cycle before.
  a_valid_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(accept))
    else $error("result strobe without a command");

  // A dropped insert leaves the count unchanged.
  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full && in_i.command == spq_pkg::CmdInsert) |=> $stable(count_q))
    else $error("insert into full queue changed the count");

  // The reported empty flag agrees with the stored count.
  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (res_q.now_empty == (count_q == '0)))
    else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts it left or right.
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire spq_pkg::entry_t    new_entry_i,
  input  wire logic               occupied_i,
  input  wire logic               prev_ge_i,
  input  wire spq_pkg::entry_t    left_entry_i,
  input  wire spq_pkg::entry_t    right_entry_i,
  output logic                    ge_o,
  output spq_pkg::entry_t         entry_o
);

  spq_pkg::entry_t data_q, data_d;

  // This cell lies at or beyond the insertion point when it is empty or its
  // key is strictly greater, which keeps equal keys in arrival order.
  assign ge_o = !occupied_i || (data_q.key > new_entry_i.key);

  // Insert: cells past the insertion point take their left neighbour, the
  // cell at that point takes the new word. Remove: every cell takes its
  // right neighbour; the last cell keeps its own entry.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.do_insert) begin
      if (prev_ge_i) begin
        data_d = left_entry_i;
      end else if (ge_o) begin
        data_d = new_entry_i;
      end
    end else if (ctrl_i.do_remove) begin
      data_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign entry_o = data_q;

endmodule

`default_nettype wire
